// ===== rtl/tls_pkg.sv =====
// shared types and constants of the thresholded laplacian stencil
`default_nettype none

package tls_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 2'd2;

    // item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // field widths
    localparam int PIX_W = 16;
    localparam int THR_W = 16;
    localparam int LAP_W = 19;

    // one term holds a difference of two pixels of up to 24 bits
    localparam int TERM_W = 25;
    localparam int SUM_W  = TERM_W + 2;

    localparam logic signed [SUM_W-1:0] LAP_MAX = SUM_W'(262143);
    localparam logic signed [SUM_W-1:0] LAP_MIN = -SUM_W'(262144);

    typedef struct packed {
        logic eor;
        logic eof;
    } t_tag;

    typedef struct packed {
        logic [3:0][TERM_W-1:0] terms;
        t_tag                   tag;
    } t_stage;

endpackage

`default_nettype wire

// ===== rtl/tls_stream_if.sv =====
// valid/ready stream interfaces for pixel items and laplacian result items
`default_nettype none

interface tls_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [tls_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface tls_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tls_pkg::LAP_W-1:0]  lap_value;
    logic                              end_of_row;
    logic                              end_of_frame;

    modport source (output valid, output lap_value, output end_of_row,
                    output end_of_frame, input ready);
    modport sink   (input valid, input lap_value, input end_of_row,
                    input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/tls_line_mem.sv =====
// single line store, one write and one registered read port, write-first
`default_nettype none

module tls_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // same-entry write forwards the new data
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tls_lap_out.sv =====
// sum of the four terms, saturation and the output register
`default_nettype none

module tls_lap_out (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire tls_pkg::t_stage i_stage,
    output logic                 o_ready,
    tls_out_if.source            o_lap
);

    logic signed [tls_pkg::SUM_W-1:0] w_sum;
    logic signed [tls_pkg::LAP_W-1:0] w_sat;
    logic                             r_valid;
    logic signed [tls_pkg::LAP_W-1:0] r_lap;
    tls_pkg::t_tag                    r_tag;

    always_comb begin
        w_sum = tls_pkg::SUM_W'($signed(i_stage.terms[0]))
              + tls_pkg::SUM_W'($signed(i_stage.terms[1]))
              + tls_pkg::SUM_W'($signed(i_stage.terms[2]))
              + tls_pkg::SUM_W'($signed(i_stage.terms[3]));
        if (w_sum > tls_pkg::LAP_MAX) begin
            w_sat = tls_pkg::LAP_MAX[tls_pkg::LAP_W-1:0];
        end else if (w_sum < tls_pkg::LAP_MIN) begin
            w_sat = tls_pkg::LAP_MIN[tls_pkg::LAP_W-1:0];
        end else begin
            w_sat = w_sum[tls_pkg::LAP_W-1:0];
        end
    end

    assign o_ready = !r_valid || o_lap.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lap <= w_sat;
            r_tag <= i_stage.tag;
        end
    end

    assign o_lap.valid        = r_valid;
    assign o_lap.lap_value    = r_lap;
    assign o_lap.end_of_row   = r_tag.eor;
    assign o_lap.end_of_frame = r_tag.eof;

    // a frame end is always a row end
    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_tag.eof |-> r_tag.eor)
        else $error("end of frame without end of row");

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_lap.ready |=> r_valid && $stable(r_lap) && $stable(r_tag))
        else $error("stalled result changed");

    // a full output register with no taker blocks the stage before
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_lap.ready |-> !o_ready)
        else $error("output register accepted while full");

endmodule

`default_nettype wire

// ===== rtl/thresholded_laplacian_stencil.sv =====
// top level of the thresholded laplacian stencil over a raster pixel stream
// throughput: one item per clock unless the output stalls, no stall between rows or frames
// a result is registered in the term stage, then summed and saturated into the
//   output register
// the line stores are read one column ahead, so a read never waits on the port
// reset: counters cleared, width 640, height 480, threshold 0; line stores are not cleared
`default_nettype none

module thresholded_laplacian_stencil #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tls_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tls_in_if.sink                                i_pix_in,
    tls_out_if.source                             o_lap_out
);

    localparam int CW = $clog2(MAX_WIDTH);       // column address
    localparam int WW = $clog2(MAX_WIDTH + 1);   // width value
    localparam int RW = $clog2(MAX_HEIGHT + 1);  // row count, up to the height itself
    localparam int TW = tls_pkg::TERM_W;

    // configuration registers
    logic [11:0]               r_frame_width;
    logic [12:0]               r_frame_height;
    logic [tls_pkg::THR_W-1:0] r_diff_threshold;
    logic                      w_cfg_hit;

    // frame position
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [WW-1:0] w_width;
    logic [RW-1:0] w_height;
    logic          w_drain;
    logic          w_last_col;

    // pixel window
    logic [PIXEL_BITS-1:0] r_center, n_center;
    logic [PIXEL_BITS-1:0] r_left;
    logic [PIXEL_BITS-1:0] r_first;
    logic [PIXEL_BITS-1:0] w_pix;
    logic [PIXEL_BITS-1:0] w_right;
    logic [PIXEL_BITS-1:0] w_up;

    // handshake and stage control
    logic            w_take;
    logic            w_act;
    logic            w_emit;
    logic            w_a_ready;
    logic            w_b_ready;
    logic            r_a_valid;
    tls_pkg::t_stage r_a_stage;
    tls_pkg::t_stage w_stage;

    // thresholded difference, zero when the neighbour is missing
    function automatic logic signed [TW-1:0] f_term(
        input logic [TW-1:0]               center,
        input logic [TW-1:0]               nb,
        input logic [tls_pkg::THR_W-1:0]   thr,
        input logic                        en
    );
        logic signed [TW-1:0] d;
        logic        [TW-1:0] mag;
        d   = $signed(center - nb);
        mag = d[TW-1] ? -d : d;
        return (en && (mag > TW'(thr))) ? d : '0;
    endfunction

    // ---------------------------------------------------------------- config
    always_comb begin
        case (i_cfg_index)
            tls_pkg::CFG_FRAME_WIDTH:    w_cfg_hit = i_cfg_we;
            tls_pkg::CFG_FRAME_HEIGHT:   w_cfg_hit = i_cfg_we;
            tls_pkg::CFG_DIFF_THRESHOLD: w_cfg_hit = i_cfg_we;
            default:                     w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= 12'd640;
            r_frame_height   <= 13'd480;
            r_diff_threshold <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tls_pkg::CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data[11:0];
                tls_pkg::CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data[12:0];
                tls_pkg::CFG_DIFF_THRESHOLD: r_diff_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero counts as one, too large clamps to the maximum
    always_comb begin
        if (r_frame_width == '0) begin
            w_width = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            w_height = RW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            w_height = RW'(MAX_HEIGHT);
        end else begin
            w_height = RW'(r_frame_height);
        end
    end

    // ---------------------------------------------------------------- control
    assign w_drain    = (r_row == w_height);
    assign w_last_col = ((WW'(r_col) + WW'(1)) == w_width);
    assign w_pix      = PIXEL_BITS'(i_pix_in.pixel);

    assign i_pix_in.ready = w_a_ready;
    assign w_take = i_pix_in.valid && w_a_ready;
    // an op that does not fit the phase is taken and dropped
    assign w_act  = w_take && (w_drain ? (i_pix_in.op == tls_pkg::OP_FLUSH)
                                       : (i_pix_in.op == tls_pkg::OP_PIXEL));
    // the first row only fills the store
    assign w_emit = w_act && (w_drain || (r_row != '0));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (w_act) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_drain ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // the center moves one column right; at a row wrap it comes from column zero
    always_comb begin
        n_center = r_center;
        if (w_act) begin
            if (w_last_col) begin
                n_center = (r_col == '0) ? w_pix : r_first;
            end else begin
                n_center = w_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_center <= n_center;
        if (w_act) begin
            r_left <= r_center;
        end
        if (w_act && !w_drain && (r_col == '0)) begin
            r_first <= w_pix;
        end
    end

    // ---------------------------------------------------------------- line stores
    // prev row store: read at the column right of the next center
    tls_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIXEL_BITS)
    ) u_prev_row (
        .i_clk   (i_clk),
        .i_we    (w_act && !w_drain),
        .i_waddr (r_col),
        .i_wdata (w_pix),
        .i_raddr (n_col + CW'(1)),
        .o_rdata (w_right)
    );

    // older row store: read at the next center column for the pixel above
    tls_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIXEL_BITS)
    ) u_older_row (
        .i_clk   (i_clk),
        .i_we    (w_emit),
        .i_waddr (r_col),
        .i_wdata (r_center),
        .i_raddr (n_col),
        .o_rdata (w_up)
    );

    // ---------------------------------------------------------------- term stage
    always_comb begin
        w_stage.terms[0] = f_term(TW'(r_center), TW'(r_left), r_diff_threshold,
                                  r_col != '0);
        w_stage.terms[1] = f_term(TW'(r_center), TW'(w_right), r_diff_threshold,
                                  !w_last_col);
        w_stage.terms[2] = f_term(TW'(r_center), TW'(w_up), r_diff_threshold,
                                  w_drain ? (w_height > RW'(1)) : (r_row > RW'(1)));
        w_stage.terms[3] = f_term(TW'(r_center), TW'(w_pix), r_diff_threshold,
                                  !w_drain);
        w_stage.tag.eor  = w_last_col;
        w_stage.tag.eof  = w_drain && w_last_col;
    end

    assign w_a_ready = !r_a_valid || w_b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && w_emit) begin
            r_a_stage <= w_stage;
        end
    end

    // ---------------------------------------------------------------- output
    tls_lap_out u_lap_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .i_stage (r_a_stage),
        .o_ready (w_b_ready),
        .o_lap   (o_lap_out)
    );

    // ---------------------------------------------------------------- checks
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < w_width)
        else $error("column beyond frame width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cfg_hit |=> r_row <= w_height)
        else $error("row beyond frame height");

    a_drain_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_act && w_drain && w_last_col && !w_cfg_hit |=> (r_row == '0) && (r_col == '0))
        else $error("frame did not restart after the last flush");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !w_b_ready |=> r_a_valid && $stable(r_a_stage))
        else $error("term stage lost an item under stall");

endmodule

`default_nettype wire
